FILE: src/csmm_pkg.sv
package csmm_pkg;

  // Field widths of one request and one result.
  localparam int TYPE_W = 2;
  localparam int ROW_W = 7;
  localparam int COL_W = 6;
  localparam int SLOT_W = 10;
  localparam int PTR_W = 11;
  localparam int DATA_W = 32;
  localparam int OUT_IDX_W = 6;
  localparam int ACC_W = 64;
  localparam int FRAC_W = 16;

  // Request kinds; the encoding matches the req_type field.
  typedef enum logic [TYPE_W-1:0] {
    OP_LD_PTR   = 2'd0,
    OP_LD_NZ    = 2'd1,
    OP_LD_DENSE = 2'd2,
    OP_MAC      = 2'd3
  } cmd_op_t;

  // One classified command as it travels from the front end to the engine.
  typedef struct packed {
    cmd_op_t                  op;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic [SLOT_W-1:0]        slot;
    logic [PTR_W-1:0]         pointer;
    logic signed [DATA_W-1:0] data;
  } cmd_t;

endpackage

FILE: src/csmm_if.sv
interface csmm_req_if;
  logic                              valid;
  logic                              ready;
  logic [csmm_pkg::TYPE_W-1:0]       req_type;
  logic [csmm_pkg::ROW_W-1:0]        row;
  logic [csmm_pkg::COL_W-1:0]        col;
  logic [csmm_pkg::SLOT_W-1:0]       slot;
  logic [csmm_pkg::PTR_W-1:0]        pointer;
  logic signed [csmm_pkg::DATA_W-1:0] data_value;

  modport source (
    output valid, req_type, row, col, slot, pointer, data_value,
    input  ready
  );
  modport sink (
    input  valid, req_type, row, col, slot, pointer, data_value,
    output ready
  );
endinterface

interface csmm_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [csmm_pkg::DATA_W-1:0] result_value;
  logic [csmm_pkg::OUT_IDX_W-1:0]     result_row;
  logic [csmm_pkg::OUT_IDX_W-1:0]     result_col;
  logic                               saturated;

  modport source (
    output valid, result_value, result_row, result_col, saturated,
    input  ready
  );
  modport sink (
    input  valid, result_value, result_row, result_col, saturated,
    output ready
  );
endinterface

FILE: src/csmm_front.sv
module csmm_front #(
  parameter int MAX_ROWS  = 64,
  parameter int MAX_INNER = 64,
  parameter int MAX_COLS  = 64,
  parameter int MAX_NNZ   = 1024
) (
  csmm_req_if.sink         request,
  input  logic             q_full,
  output logic             push,
  output csmm_pkg::cmd_t   cmd
);

  logic keep;

  // A request is taken whenever the command queue has room.
  assign request.ready = !q_full;

  // Drop requests whose indexes fall outside the stored arrays.
  always_comb begin
    unique case (csmm_pkg::cmd_op_t'(request.req_type))
      csmm_pkg::OP_LD_PTR:   keep = 32'(request.row) <= MAX_ROWS;
      csmm_pkg::OP_LD_NZ:    keep = 32'(request.slot) < MAX_NNZ;
      csmm_pkg::OP_LD_DENSE: keep = (32'(request.row) < MAX_INNER) &&
                                    (32'(request.col) < MAX_COLS);
      csmm_pkg::OP_MAC:      keep = (32'(request.row) < MAX_ROWS) &&
                                    (32'(request.col) < MAX_COLS);
      default:               keep = 1'b0;
    endcase
  end

  // Pack the surviving request into a queue entry.
  always_comb begin
    cmd.op      = csmm_pkg::cmd_op_t'(request.req_type);
    cmd.row     = request.row;
    cmd.col     = request.col;
    cmd.slot    = request.slot;
    cmd.pointer = request.pointer;
    cmd.data    = request.data_value;
  end

  assign push = request.valid && request.ready && keep;

endmodule

FILE: src/csmm_queue.sv
module csmm_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  csmm_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output csmm_pkg::cmd_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  csmm_pkg::cmd_t entries [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full    = count == CW'(DEPTH);
  assign valid   = count != '0;
  assign head    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // Pointer and occupancy bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

FILE: src/csmm_engine.sv
module csmm_engine #(
  parameter int MAX_ROWS  = 64,
  parameter int MAX_INNER = 64,
  parameter int MAX_COLS  = 64,
  parameter int MAX_NNZ   = 1024
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  csmm_pkg::cmd_t q_cmd,
  output logic           pop,
  csmm_rsp_if.source     result
);

  localparam int RP_DEPTH = MAX_ROWS + 1;
  localparam int RP_AW    = $clog2(RP_DEPTH);
  localparam int NZ_AW    = (MAX_NNZ > 1) ? $clog2(MAX_NNZ) : 1;
  localparam int DN_DEPTH = MAX_INNER * MAX_COLS;
  localparam int DN_AW    = (DN_DEPTH > 1) ? $clog2(DN_DEPTH) : 1;
  localparam int IDX_W    = $clog2(MAX_NNZ + 1);
  localparam int DW       = csmm_pkg::DATA_W;
  localparam int AW64     = csmm_pkg::ACC_W;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PTR   = 5'b00010,
    ST_WALK  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  // Storage for the sparse operand, its row pointers and the dense operand.
  logic [csmm_pkg::PTR_W-1:0] rp_mem     [RP_DEPTH];
  logic [csmm_pkg::COL_W-1:0] nz_col_mem [MAX_NNZ];
  logic signed [DW-1:0]       nz_val_mem [MAX_NNZ];
  logic signed [DW-1:0]       dense_mem  [DN_DEPTH];

  state_t                     state;
  state_t                     state_next;
  logic [csmm_pkg::PTR_W-1:0] rp_lo;
  logic [csmm_pkg::PTR_W-1:0] rp_hi;
  logic [csmm_pkg::ROW_W-1:0] cur_row;
  logic [csmm_pkg::COL_W-1:0] cur_col;
  logic [IDX_W-1:0]           idx;
  logic [IDX_W-1:0]           end_idx;
  logic                       s1_valid;
  logic                       s2_valid;
  logic                       s3_valid;
  logic [csmm_pkg::COL_W-1:0] nz_col;
  logic signed [DW-1:0]       nz_val;
  logic signed [DW-1:0]       dn_val;
  logic signed [DW-1:0]       nz_val_d;
  logic signed [AW64-1:0]     prod;
  logic signed [AW64-1:0]     acc;
  logic                       out_valid;
  logic signed [DW-1:0]       out_value;
  logic [csmm_pkg::OUT_IDX_W-1:0] out_row;
  logic [csmm_pkg::OUT_IDX_W-1:0] out_col;
  logic                       out_sat;

  logic                       is_mac;
  logic                       issue;
  logic                       col_ok;
  logic [31:0]                dn_rd_lin;
  logic [31:0]                dn_wr_lin;
  logic                       sat_hi;
  logic                       sat_lo;
  logic                       load_out;

  // Clamp a stored row pointer to the nonzero capacity.
  function automatic logic [IDX_W-1:0] clamp_ptr(input logic [csmm_pkg::PTR_W-1:0] p);
    if (32'(p) > MAX_NNZ) begin
      return IDX_W'(MAX_NNZ);
    end
    return IDX_W'(p);
  endfunction

  assign pop       = (state == ST_IDLE) && q_valid;
  assign is_mac    = q_cmd.op == csmm_pkg::OP_MAC;
  assign issue     = (state == ST_WALK) && (idx < end_idx);
  assign col_ok    = 32'(nz_col) < MAX_INNER;
  assign dn_rd_lin = 32'(nz_col) * MAX_COLS + 32'(cur_col);
  assign dn_wr_lin = 32'(q_cmd.row) * MAX_COLS + 32'(q_cmd.col);
  assign sat_hi    = acc > 64'sd2147483647;
  assign sat_lo    = acc < -64'sd2147483648;
  assign load_out  = (state == ST_DONE) && (!out_valid || result.ready);

  // Sequencer for one command at a time.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (pop && is_mac) state_next = ST_PTR;
      ST_PTR:   state_next = ST_WALK;
      ST_WALK:  if (!issue) state_next = ST_DRAIN;
      ST_DRAIN: if (!s1_valid && !s2_valid && !s3_valid) state_next = ST_DONE;
      ST_DONE:  if (load_out) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Control state: sequencer, pipeline valids and the result register flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      s1_valid  <= issue;
      s2_valid  <= s1_valid && col_ok;
      s3_valid  <= s2_valid;
      out_valid <= load_out || (out_valid && !result.ready);
    end
  end

  // Row pointer table: written by loads, read at the row and the next row.
  always_ff @(posedge clk) begin
    if (pop && q_cmd.op == csmm_pkg::OP_LD_PTR) begin
      rp_mem[RP_AW'(q_cmd.row)] <= q_cmd.pointer;
    end
    if (pop && is_mac) begin
      rp_lo <= rp_mem[RP_AW'(q_cmd.row)];
      rp_hi <= rp_mem[RP_AW'(32'(q_cmd.row) + 1)];
    end
  end

  // Nonzero arrays: written by loads, read once per walked nonzero.
  always_ff @(posedge clk) begin
    if (pop && q_cmd.op == csmm_pkg::OP_LD_NZ) begin
      nz_col_mem[NZ_AW'(q_cmd.slot)] <= q_cmd.col;
      nz_val_mem[NZ_AW'(q_cmd.slot)] <= q_cmd.data;
    end
    if (issue) begin
      nz_col <= nz_col_mem[NZ_AW'(idx)];
      nz_val <= nz_val_mem[NZ_AW'(idx)];
    end
  end

  // Dense matrix, row-major: read at the nonzero's column index.
  always_ff @(posedge clk) begin
    if (pop && q_cmd.op == csmm_pkg::OP_LD_DENSE) begin
      dense_mem[DN_AW'(dn_wr_lin)] <= q_cmd.data;
    end
    if (s1_valid) begin
      dn_val   <= dense_mem[DN_AW'(dn_rd_lin)];
      nz_val_d <= nz_val;
    end
  end

  // Walk counters, multiply and floor-accumulate datapath.
  always_ff @(posedge clk) begin
    if (pop && is_mac) begin
      cur_row <= q_cmd.row;
      cur_col <= q_cmd.col;
    end
    if (state == ST_PTR) begin
      idx     <= clamp_ptr(rp_lo);
      end_idx <= clamp_ptr(rp_hi);
      acc     <= '0;
    end else if (issue) begin
      idx <= idx + 1'b1;
    end
    if (s2_valid) begin
      prod <= dn_val * nz_val_d;
    end
    // An arithmetic shift floors the Q32.32 product to Q48.16.
    if (s3_valid) begin
      acc <= acc + (prod >>> csmm_pkg::FRAC_W);
    end
  end

  // Result register with saturation to the 32-bit range.
  always_ff @(posedge clk) begin
    if (load_out) begin
      if (sat_hi) begin
        out_value <= 32'sh7FFFFFFF;
      end else if (sat_lo) begin
        out_value <= 32'sh80000000;
      end else begin
        out_value <= acc[DW-1:0];
      end
      out_sat <= sat_hi || sat_lo;
      out_row <= cur_row[csmm_pkg::OUT_IDX_W-1:0];
      out_col <= cur_col;
    end
  end

  assign result.valid        = out_valid;
  assign result.result_value = out_value;
  assign result.result_row   = out_row;
  assign result.result_col   = out_col;
  assign result.saturated    = out_sat;

endmodule

FILE: src/csr_sparse_dense_matmul_unit.sv
// Load requests pass the command queue and the engine at one per cycle unless a compute
// holds the engine; each load is written into its memory at the same clock edge at which
// the engine takes it from the queue. A compute request on a row of n nonzeros walks the
// row one nonzero per cycle through a four-stage read, read, multiply, accumulate
// pipeline; the engine handles one command at a time and is busy with each compute until
// its result is registered, longer while the receiver holds the previous result.
// Synchronous active-high reset empties the queue and clears all control state;
// the matrix memories are not cleared and hold nothing defined until loaded.
module csr_sparse_dense_matmul_unit #(
  parameter int MAX_ROWS  = 64,
  parameter int MAX_INNER = 64,
  parameter int MAX_COLS  = 64,
  parameter int MAX_NNZ   = 1024
) (
  input  logic        clk,
  input  logic        rst,
  csmm_req_if.sink    request,
  csmm_rsp_if.source  result
);

  localparam int QUEUE_DEPTH = 4;

  logic           push;
  logic           q_full;
  logic           q_valid;
  logic           pop;
  csmm_pkg::cmd_t push_cmd;
  csmm_pkg::cmd_t q_cmd;

  // Front end: accept and classify requests.
  csmm_front #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_INNER (MAX_INNER),
    .MAX_COLS  (MAX_COLS),
    .MAX_NNZ   (MAX_NNZ)
  ) u_front (
    .request (request),
    .q_full  (q_full),
    .push    (push),
    .cmd     (push_cmd)
  );

  // Command queue between front end and engine.
  csmm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .valid    (q_valid),
    .head     (q_cmd)
  );

  // Engine: memory updates and the row walk.
  csmm_engine #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_INNER (MAX_INNER),
    .MAX_COLS  (MAX_COLS),
    .MAX_NNZ   (MAX_NNZ)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .pop     (pop),
    .result  (result)
  );

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int MAX_ROWS = 64;
  localparam int MAX_INNER = 64;
  localparam int MAX_COLS = 64;
  localparam int MAX_NNZ = 1024;
  localparam int NZ_PER_ROW = MAX_NNZ / MAX_ROWS;
  localparam int CLK_PERIOD = 10;
  localparam int RESET_CYCLES = 9;
  localparam int PHASES = 10;
  localparam int ITEMS_PER_PHASE = 108;
  localparam int LONG_HOLD = 800;
  localparam int DRAIN_CYCLES = 64;
  localparam int WATCHDOG_LIMIT = 5000;

  // Field widths of the request and result.
  localparam int TYPE_W = csmm_pkg::TYPE_W;
  localparam int ROW_W = csmm_pkg::ROW_W;
  localparam int COL_W = csmm_pkg::COL_W;
  localparam int SLOT_W = csmm_pkg::SLOT_W;
  localparam int PTR_W = csmm_pkg::PTR_W;
  localparam int DATA_W = csmm_pkg::DATA_W;
  localparam int OUT_IDX_W = csmm_pkg::OUT_IDX_W;
  localparam int FRAC_W = csmm_pkg::FRAC_W;

  localparam logic signed [DATA_W-1:0] Q_TOP = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] Q_BOTTOM = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [DATA_W-1:0] Q_LSB = 32'sh0000_0001;
  localparam logic signed [DATA_W-1:0] Q_MINUS_LSB = -32'sd1;
  localparam longint Q16_HI = 64'sd2147483647;
  localparam longint Q16_LO = -64'sd2147483648;

  // One result element as it leaves the block.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [OUT_IDX_W-1:0]     row;
    logic [OUT_IDX_W-1:0]     col;
    logic                     sat;
  } result_elem_t;

  // Mirror of the matrix memories and the queue of result elements still owed.
  class matmul_scoreboard;
    logic [PTR_W-1:0]         row_ptr [MAX_ROWS+1];
    bit                       ptr_set [MAX_ROWS+1];
    logic [COL_W-1:0]         nz_col [MAX_NNZ];
    logic signed [DATA_W-1:0] nz_val [MAX_NNZ];
    bit                       nz_set [MAX_NNZ];
    logic signed [DATA_W-1:0] dense [MAX_INNER*MAX_COLS];
    bit                       dense_set [MAX_INNER*MAX_COLS];
    result_elem_t             pending_elements [$];
    int                       requests_taken;
    int                       elements_checked;
    int                       saturated_seen;
    int                       mismatches;

    // Slot range of one sparse row, with both pointers clamped to capacity.
    function void row_span(input int r, output int lo, output int hi);
      lo = (row_ptr[r] > MAX_NNZ) ? MAX_NNZ : int'(row_ptr[r]);
      hi = (row_ptr[r+1] > MAX_NNZ) ? MAX_NNZ : int'(row_ptr[r+1]);
    endfunction

    // Dot product of sparse row r with dense column c, floored per product.
    function result_elem_t row_times_column(input int r, input int c);
      result_elem_t e;
      int lo, hi, s, k;
      longint acc;
      row_span(r, lo, hi);
      acc = 0;
      for (s = lo; s < hi; s++) begin
        k = int'(nz_col[s]);
        if (k < MAX_INNER) begin
          acc += (longint'(nz_val[s]) * longint'(dense[k*MAX_COLS + c])) >>> FRAC_W;
        end
      end
      e.row = OUT_IDX_W'(r);
      e.col = OUT_IDX_W'(c);
      e.sat = 1'b1;
      if (acc > Q16_HI) begin
        e.value = Q_TOP;
      end else if (acc < Q16_LO) begin
        e.value = Q_BOTTOM;
      end else begin
        e.value = acc[DATA_W-1:0];
        e.sat = 1'b0;
      end
      return e;
    endfunction

    // Apply one accepted request to the mirror.
    function void note_request(input csmm_pkg::cmd_t rq);
      int r, c, s;
      r = int'(rq.row);
      c = int'(rq.col);
      s = int'(rq.slot);
      requests_taken++;
      case (rq.op)
        csmm_pkg::OP_LD_PTR: begin
          if (r <= MAX_ROWS) begin
            row_ptr[r] = rq.pointer;
            ptr_set[r] = 1'b1;
          end
        end
        csmm_pkg::OP_LD_NZ: begin
          if (s < MAX_NNZ) begin
            nz_col[s] = rq.col;
            nz_val[s] = rq.data;
            nz_set[s] = 1'b1;
          end
        end
        csmm_pkg::OP_LD_DENSE: begin
          if (r < MAX_INNER && c < MAX_COLS) begin
            dense[r*MAX_COLS + c] = rq.data;
            dense_set[r*MAX_COLS + c] = 1'b1;
          end
        end
        csmm_pkg::OP_MAC: begin
          if (r < MAX_ROWS && c < MAX_COLS) pending_elements.push_back(row_times_column(r, c));
        end
        default: ;
      endcase
    endfunction

    // Compare one accepted result element with the oldest one owed.
    function void check_result(input result_elem_t got);
      result_elem_t want;
      if (pending_elements.size() == 0) begin
        $error("unexpected result element: row %0d col %0d value %0d",
               got.row, got.col, got.value);
        mismatches++;
        return;
      end
      want = pending_elements.pop_front();
      elements_checked++;
      if (want.sat) saturated_seen++;
      if (got.value !== want.value) begin
        $error("result_value: expected %0d, actual %0d", want.value, got.value);
        mismatches++;
      end
      if (got.row !== want.row) begin
        $error("result_row: expected %0d, actual %0d", want.row, got.row);
        mismatches++;
      end
      if (got.col !== want.col) begin
        $error("result_col: expected %0d, actual %0d", want.col, got.col);
        mismatches++;
      end
      if (got.sat !== want.sat) begin
        $error("saturated: expected %0d, actual %0d", want.sat, got.sat);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  int   req_calm = 0;
  int   rsp_calm = 0;
  int   quiet_cycles = 0;
  matmul_scoreboard sb = new;

  csmm_req_if req_bus();
  csmm_rsp_if rsp_bus();

  csr_sparse_dense_matmul_unit #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_INNER(MAX_INNER),
    .MAX_COLS (MAX_COLS),
    .MAX_NNZ  (MAX_NNZ)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .request(req_bus),
    .result (rsp_bus)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Idle cycles before the next handshake; occasionally a calm stretch with none.
  function automatic int idle_gap(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(20, 60);
    return $urandom_range(0, 19);
  endfunction

  // Q16.16 operand: half small, some full range, some at the extremes or other special values, some zero.
  function automatic logic signed [DATA_W-1:0] pick_q16();
    logic signed [DATA_W-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = v >>> 11;
      8: begin
        case ($urandom_range(0, 3))
          0: v = Q_TOP;
          1: v = Q_BOTTOM;
          2: v = Q_ONE;
          default: v = Q_MINUS_LSB;
        endcase
      end
      9: v = '0;
      default: ;
    endcase
    return v;
  endfunction

  // Row pointer near its nominal place, sometimes overlapping the next row,
  // and past capacity only for the last rows so that spans stay short.
  function automatic logic [PTR_W-1:0] pick_pointer(input int p);
    if (p >= MAX_ROWS - 3 && $urandom_range(0, 4) == 0) begin
      return PTR_W'($urandom_range(MAX_NNZ + 1, (1 << PTR_W) - 1));
    end
    if ($urandom_range(0, 9) == 0) begin
      return PTR_W'(p * NZ_PER_ROW + $urandom_range(NZ_PER_ROW + 1, 2 * NZ_PER_ROW - 1));
    end
    return PTR_W'(p * NZ_PER_ROW + $urandom_range(0, NZ_PER_ROW));
  endfunction

  function automatic csmm_pkg::cmd_t random_cmd();
    csmm_pkg::cmd_t rq;
    rq.op = csmm_pkg::cmd_op_t'($urandom_range(0, 3));
    rq.row = ROW_W'($urandom_range(0, (1 << ROW_W) - 1));
    rq.col = COL_W'($urandom_range(0, (1 << COL_W) - 1));
    rq.slot = SLOT_W'($urandom_range(0, (1 << SLOT_W) - 1));
    rq.pointer = PTR_W'($urandom_range(0, (1 << PTR_W) - 1));
    rq.data = $urandom;
    return rq;
  endfunction

  // Find the first entry a compute of (r, c) would read that was never loaded,
  // and build the load request that fills it.
  function automatic bit find_missing(input int r, input int c, output csmm_pkg::cmd_t fix);
    int lo, hi, s, k;
    fix = random_cmd();
    fix.data = pick_q16();
    if (!sb.ptr_set[r] || !sb.ptr_set[r+1]) begin
      fix.op = csmm_pkg::OP_LD_PTR;
      fix.row = sb.ptr_set[r] ? ROW_W'(r + 1) : ROW_W'(r);
      fix.pointer = pick_pointer(int'(fix.row));
      return 1'b1;
    end
    sb.row_span(r, lo, hi);
    for (s = lo; s < hi; s++) begin
      if (!sb.nz_set[s]) begin
        fix.op = csmm_pkg::OP_LD_NZ;
        fix.slot = SLOT_W'(s);
        return 1'b1;
      end
      k = int'(sb.nz_col[s]);
      if (k < MAX_INNER && !sb.dense_set[k*MAX_COLS + c]) begin
        fix.op = csmm_pkg::OP_LD_DENSE;
        fix.row = ROW_W'(k);
        fix.col = COL_W'(c);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Offer one request after a random gap and wait until it is accepted.
  task automatic push_request(input csmm_pkg::cmd_t rq);
    int gap;
    gap = idle_gap(req_calm);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.req_type <= rq.op;
    req_bus.row <= rq.row;
    req_bus.col <= rq.col;
    req_bus.slot <= rq.slot;
    req_bus.pointer <= rq.pointer;
    req_bus.data_value <= rq.data;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    sb.note_request(rq);
  endtask

  task automatic send_fields(input csmm_pkg::cmd_op_t op, input int row, input int col,
                             input int slot, input int ptr,
                             input logic signed [DATA_W-1:0] v);
    csmm_pkg::cmd_t rq;
    rq.op = op;
    rq.row = ROW_W'(row);
    rq.col = COL_W'(col);
    rq.slot = SLOT_W'(slot);
    rq.pointer = PTR_W'(ptr);
    rq.data = v;
    push_request(rq);
  endtask

  // Stop offering and wait until every owed result element has come back.
  task automatic wait_for_results();
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (sb.pending_elements.size() != 0);
  endtask

  // One phase works on a few neighboring rows and a few columns, so that
  // computes find their operands loaded and loads keep changing them.
  task automatic run_phase(input int n_items);
    csmm_pkg::cmd_t rq, fix;
    int base_row, r, c, sel, lo, hi, i;
    int cols [3];
    base_row = $urandom_range(0, MAX_ROWS - 4);
    foreach (cols[j]) cols[j] = $urandom_range(0, MAX_COLS - 1);
    for (i = 0; i < n_items; i++) begin
      rq = random_cmd();
      rq.data = pick_q16();
      r = base_row + $urandom_range(0, 3);
      c = cols[$urandom_range(0, 2)];
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        if (find_missing(r, c, fix)) begin
          rq = fix;
        end else begin
          rq.op = csmm_pkg::OP_MAC;
          rq.row = ROW_W'(r);
          rq.col = COL_W'(c);
        end
      end else if (sel < 65) begin
        // Rewrite a nonzero of a working row.
        rq.op = csmm_pkg::OP_LD_NZ;
        if (sb.ptr_set[r] && sb.ptr_set[r+1]) begin
          sb.row_span(r, lo, hi);
          if (lo < hi) rq.slot = SLOT_W'($urandom_range(lo, hi - 1));
        end
      end else if (sel < 80) begin
        rq.op = csmm_pkg::OP_LD_DENSE;
        rq.row = ROW_W'($urandom_range(0, MAX_INNER - 1));
        rq.col = COL_W'(c);
      end else if (sel < 88) begin
        rq.op = csmm_pkg::OP_LD_PTR;
        rq.row = ROW_W'(r + $urandom_range(0, 1));
        rq.pointer = pick_pointer(int'(rq.row));
      end else begin
        // Noise: ignored pointer rows, any load position, computes anywhere.
        case (rq.op)
          csmm_pkg::OP_LD_PTR: begin
            rq.row = ROW_W'($urandom_range(MAX_ROWS + 1, (1 << ROW_W) - 1));
          end
          csmm_pkg::OP_MAC: begin
            if (rq.row < MAX_ROWS && find_missing(int'(rq.row), int'(rq.col), fix)) rq = fix;
          end
          default: ;
        endcase
      end
      push_request(rq);
    end
  endtask

  // Result side: random ready gaps, plus one long hold while requests keep coming.
  initial begin
    result_elem_t got;
    int hold;
    bit held_once;
    hold = 0;
    held_once = 1'b0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) continue;
      if (rsp_bus.valid && rsp_bus.ready) begin
        got.value = rsp_bus.result_value;
        got.row = rsp_bus.result_row;
        got.col = rsp_bus.result_col;
        got.sat = rsp_bus.saturated;
        sb.check_result(got);
        if (!held_once && sb.elements_checked >= 30 && req_bus.valid) begin
          hold = LONG_HOLD;
          held_once = 1'b1;
        end else begin
          hold = idle_gap(rsp_calm);
        end
        if (hold > 0) rsp_bus.ready <= 1'b0;
      end else if (!rsp_bus.ready) begin
        if (hold > 0) hold--;
        if (hold == 0) rsp_bus.ready <= 1'b1;
      end
    end
  end

  // Watchdog: cycles in which no request and no result element moved.
  always @(posedge clk) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("tb: errors");
    $finish;
  end

  // Main sequence: reset, directed cases, random phases, drain.
  initial begin
    int p;
    rst <= 1'b1;
    req_bus.valid <= 1'b0;
    req_bus.req_type <= csmm_pkg::OP_LD_PTR;
    req_bus.row <= '0;
    req_bus.col <= '0;
    req_bus.slot <= '0;
    req_bus.pointer <= '0;
    req_bus.data_value <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Row 1 empty, row 2 reversed, row 63 ends past capacity, row 127 ignored.
    send_fields(csmm_pkg::OP_LD_PTR, 0, 0, 0, 0, '0);
    send_fields(csmm_pkg::OP_LD_PTR, 1, 0, 0, 3, '0);
    send_fields(csmm_pkg::OP_LD_PTR, 2, 0, 0, 3, '0);
    send_fields(csmm_pkg::OP_LD_PTR, 3, 0, 0, 1, '0);
    send_fields(csmm_pkg::OP_LD_PTR, 63, 0, 0, MAX_NNZ - 2, '0);
    send_fields(csmm_pkg::OP_LD_PTR, 64, 0, 0, (1 << PTR_W) - 1, '0);
    send_fields(csmm_pkg::OP_LD_PTR, (1 << ROW_W) - 1, 0, 0, MAX_NNZ, '0);
    send_fields(csmm_pkg::OP_LD_NZ, 0, 0, 0, 0, Q_TOP);
    send_fields(csmm_pkg::OP_LD_NZ, 0, 63, 1, 0, Q_TOP);
    send_fields(csmm_pkg::OP_LD_NZ, 0, 1, 2, 0, Q_BOTTOM);
    send_fields(csmm_pkg::OP_LD_NZ, 0, 5, MAX_NNZ - 2, 0, Q_MINUS_LSB);
    send_fields(csmm_pkg::OP_LD_NZ, 0, 63, MAX_NNZ - 1, 0, Q_ONE);
    // Column 0 drives row 0 to positive saturation, column 1 to negative.
    send_fields(csmm_pkg::OP_LD_DENSE, 0, 0, 0, 0, Q_TOP);
    send_fields(csmm_pkg::OP_LD_DENSE, 63, 0, 0, 0, Q_TOP);
    send_fields(csmm_pkg::OP_LD_DENSE, 1, 0, 0, 0, Q_TOP);
    send_fields(csmm_pkg::OP_LD_DENSE, 5, 0, 0, 0, Q_LSB);
    send_fields(csmm_pkg::OP_LD_DENSE, (1 << ROW_W) - 1, 63, 0, 0, Q_TOP);
    send_fields(csmm_pkg::OP_LD_DENSE, 0, 1, 0, 0, Q_BOTTOM);
    send_fields(csmm_pkg::OP_LD_DENSE, 63, 1, 0, 0, Q_BOTTOM);
    send_fields(csmm_pkg::OP_LD_DENSE, 1, 1, 0, 0, Q_TOP);
    send_fields(csmm_pkg::OP_MAC, 0, 0, 0, 0, '0);
    send_fields(csmm_pkg::OP_MAC, 0, 1, 0, 0, '0);
    send_fields(csmm_pkg::OP_MAC, 1, 0, 0, 0, '0);
    send_fields(csmm_pkg::OP_MAC, 2, 0, 0, 0, '0);
    send_fields(csmm_pkg::OP_MAC, 63, 0, 0, 0, '0);
    send_fields(csmm_pkg::OP_MAC, 64, 0, 0, 0, '0);
    send_fields(csmm_pkg::OP_MAC, (1 << ROW_W) - 1, 63, 0, 0, '0);
    wait_for_results();

    for (p = 0; p < PHASES; p++) begin
      run_phase(ITEMS_PER_PHASE);
      wait_for_results();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests in %0d random phases; %0d result elements checked,",
             sb.requests_taken, PHASES, sb.elements_checked);
    $display("%0d of them saturated, %0d mismatches.", sb.saturated_seen, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
